>>> rtl/spr_pkg.sv
// Shared widths, register indexes and inter-stage payload types for the
// spring-damper force pipeline. No dependencies.
`default_nettype none

package spr_pkg;

  // Q16.16 value format
  localparam int VALUE_W = 32;
  localparam int FRAC_W  = 16;

  // Derived datapath widths
  localparam int DIFF_W = VALUE_W + 1;      // position / velocity difference
  localparam int SQ_W   = 2 * DIFF_W;       // squared length, Q34.32
  localparam int ROOT_W = DIFF_W;           // spring length, Q17.16 unsigned
  localparam int NUM_W  = DIFF_W + FRAC_W;  // divider numerator
  localparam int QUO_W  = FRAC_W + 1;       // unit-vector magnitude, <= 1.0
  localparam int CFG_W  = VALUE_W - 1;      // config register width
  localparam int IDX_W  = 2;

  // Config register indexes
  localparam logic [IDX_W-1:0] REG_STIFFNESS   = 2'd0;
  localparam logic [IDX_W-1:0] REG_DAMPING     = 2'd1;
  localparam logic [IDX_W-1:0] REG_REST_LENGTH = 2'd2;

  // Payload carried alongside the square root
  typedef struct packed {
    logic [2:0][DIFF_W-1:0] d;    // second - first position
    logic [2:0][DIFF_W-1:0] dv;   // first - second velocity
    logic                   zero; // bodies coincide
  } spr_side_t;

  // Divider result and the payload that travels with it
  typedef struct packed {
    logic [2:0][QUO_W-1:0]  q;    // |unit vector| per axis
    logic [2:0]             neg;  // axis sign
    logic [2:0][DIFF_W-1:0] dv;
    logic [ROOT_W-1:0]      len;
    logic                   zero;
  } spr_quot_t;

endpackage

`default_nettype wire

>>> rtl/damped_spring_force.sv
// Spring-damper force on the first of two bodies, Q16.16, fully pipelined.
// Depends on spr_pkg, spr_sqrt, spr_div.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid/in_ready   | first/second position, velocity
//   out_    | output    | out_valid/out_ready | force x/y/z, coincident
//   cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One item per cycle while results are taken; 3 front stages, 33 square-root
// stages, 17 divider stages, 8 back stages ending in the output register.
// Reset (synchronous, active low) clears valid bits and loads stiffness 1.0,
// damping 0, rest length 1.0. A waiting output stalls the whole pipeline in
// place; in_ready is low only while a result waits untaken.
`default_nettype none

module damped_spring_force (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [spr_pkg::VALUE_W-1:0] in_first_x,
  input  logic signed [spr_pkg::VALUE_W-1:0] in_first_y,
  input  logic signed [spr_pkg::VALUE_W-1:0] in_first_z,
  input  logic signed [spr_pkg::VALUE_W-1:0] in_second_x,
  input  logic signed [spr_pkg::VALUE_W-1:0] in_second_y,
  input  logic signed [spr_pkg::VALUE_W-1:0] in_second_z,
  input  logic signed [spr_pkg::VALUE_W-1:0] in_first_vx,
  input  logic signed [spr_pkg::VALUE_W-1:0] in_first_vy,
  input  logic signed [spr_pkg::VALUE_W-1:0] in_first_vz,
  input  logic signed [spr_pkg::VALUE_W-1:0] in_second_vx,
  input  logic signed [spr_pkg::VALUE_W-1:0] in_second_vy,
  input  logic signed [spr_pkg::VALUE_W-1:0] in_second_vz,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [spr_pkg::VALUE_W-1:0] out_force_x,
  output logic signed [spr_pkg::VALUE_W-1:0] out_force_y,
  output logic signed [spr_pkg::VALUE_W-1:0] out_force_z,
  output logic                               out_coincident,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [spr_pkg::IDX_W-1:0]          cfg_index,
  input  logic [spr_pkg::CFG_W-1:0]          cfg_data
);
  import spr_pkg::*;

  // Back-end widths
  localparam int UNIT_W = QUO_W + 1;                 // signed unit component
  localparam int KD_W   = ROOT_W + 1;                // length - rest
  localparam int PW_W   = UNIT_W + DIFF_W;           // e * dv
  localparam int SUM_W  = PW_W + 2;
  localparam int W_W    = SUM_W - FRAC_W;            // relative speed
  localparam int LO_W   = 18;                        // multiplier split point
  localparam int KH_W   = CFG_W + 1 + KD_W - LO_W;
  localparam int KL_W   = CFG_W + LO_W;
  localparam int DH_W   = CFG_W + 1 + W_W - LO_W;
  localparam int DL_W   = CFG_W + LO_W;
  localparam int SC_W   = DH_W + LO_W - FRAC_W + 1;  // scaled spring / damper terms
  localparam int F_W    = VALUE_W + FRAC_W;          // clamped scalar force
  localparam int PF_W   = F_W + UNIT_W;
  localparam int SH_W   = PF_W - FRAC_W;
  localparam longint F_LIM   = (longint'(1) << (F_W - 1)) - 1;
  localparam longint OUT_MAX = (longint'(1) << (VALUE_W - 1)) - 1;
  localparam longint OUT_MIN = -OUT_MAX - 1;

  logic en;

  // Global advance: everything moves unless a result waits
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  // ---------------- config registers ----------------
  logic [CFG_W-1:0] stiff_r, damp_r, rest_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stiff_r <= CFG_W'(1) << FRAC_W;
      damp_r  <= '0;
      rest_r  <= CFG_W'(1) << FRAC_W;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_STIFFNESS:   stiff_r <= cfg_data;
        REG_DAMPING:     damp_r  <= cfg_data;
        REG_REST_LENGTH: rest_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- stage 1: differences ----------------
  logic signed [VALUE_W-1:0] fp [3], sp [3], fv [3], sv [3];
  logic signed [DIFF_W-1:0]  d1_r [3], dv1_r [3];
  logic                      v1_r;

  assign fp = '{in_first_x, in_first_y, in_first_z};
  assign sp = '{in_second_x, in_second_y, in_second_z};
  assign fv = '{in_first_vx, in_first_vy, in_first_vz};
  assign sv = '{in_second_vx, in_second_vy, in_second_vz};

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d1_r[i]  <= DIFF_W'(sp[i]) - DIFF_W'(fp[i]);
        dv1_r[i] <= DIFF_W'(fv[i]) - DIFF_W'(sv[i]);
      end
    end
  end

  // ---------------- stage 2: squares ----------------
  logic [DIFF_W-1:0] mg [3];
  logic [SQ_W-1:0]   sq2_r [3];
  spr_side_t         side2_r;
  logic              v2_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mg[i] = d1_r[i][DIFF_W-1] ? DIFF_W'(-d1_r[i]) : DIFF_W'(d1_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq2_r[i]      <= mg[i] * mg[i];
        side2_r.d[i]  <= d1_r[i];
        side2_r.dv[i] <= dv1_r[i];
      end
      side2_r.zero <= 1'b0;
    end
  end

  // ---------------- stage 3: squared length ----------------
  logic [SQ_W-1:0] rad_nxt, rad3_r;
  spr_side_t       side3_r;
  logic            v3_r;

  assign rad_nxt = sq2_r[0] + sq2_r[1] + sq2_r[2];

  always_ff @(posedge clk) begin
    if (en) begin
      rad3_r  <= rad_nxt;
      side3_r <= '{d: side2_r.d, dv: side2_r.dv, zero: (rad_nxt == '0)};
    end
  end

  // ---------------- length and unit vector ----------------
  logic              v4, v5;
  logic [ROOT_W-1:0] root4;
  spr_side_t         side4;
  spr_quot_t         quot5;

  spr_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (v3_r),
    .in_rad   (rad3_r),
    .in_side  (side3_r),
    .out_valid(v4),
    .out_root (root4),
    .out_side (side4)
  );

  spr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (v4),
    .in_root  (root4),
    .in_side  (side4),
    .out_valid(v5),
    .out_quot (quot5)
  );

  // ---------------- stage A: signed unit vector, stretch ----------------
  logic signed [UNIT_W-1:0] qs [3];
  logic signed [UNIT_W-1:0] ea_r [3];
  logic signed [DIFF_W-1:0] dva_r [3];
  logic signed [KD_W-1:0]   kda_r;
  logic                     za_r, va_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qs[i] = signed'(UNIT_W'(quot5.q[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ea_r[i]  <= quot5.neg[i] ? -qs[i] : qs[i];
        dva_r[i] <= signed'(quot5.dv[i]);
      end
      kda_r <= signed'(KD_W'(quot5.len)) - signed'(KD_W'(rest_r));
      za_r  <= quot5.zero;
    end
  end

  // ---------------- stage B: e * dv ----------------
  logic signed [PW_W-1:0]   pwb_r [3];
  logic signed [UNIT_W-1:0] eb_r [3];
  logic signed [KD_W-1:0]   kdb_r;
  logic                     zb_r, vb_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pwb_r[i] <= ea_r[i] * dva_r[i];
      end
      eb_r  <= ea_r;
      kdb_r <= kda_r;
      zb_r  <= za_r;
    end
  end

  // ---------------- stage C: relative speed along axis ----------------
  logic signed [SUM_W-1:0]  wsum;
  logic signed [W_W-1:0]    wc_r;
  logic signed [UNIT_W-1:0] ec_r [3];
  logic signed [KD_W-1:0]   kdc_r;
  logic                     zc_r, vc_r;

  assign wsum = SUM_W'(pwb_r[0]) + SUM_W'(pwb_r[1]) + SUM_W'(pwb_r[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      wc_r  <= W_W'(wsum >>> FRAC_W);
      ec_r  <= eb_r;
      kdc_r <= kdb_r;
      zc_r  <= zb_r;
    end
  end

  // ---------------- stage D: split spring and damper products ----------------
  logic signed [KH_W-1:0]   khd_r;
  logic [KL_W-1:0]          kld_r;
  logic signed [DH_W-1:0]   dhd_r;
  logic [DL_W-1:0]          dld_r;
  logic signed [UNIT_W-1:0] ed_r [3];
  logic                     zd_r, vd_r;

  always_ff @(posedge clk) begin
    if (en) begin
      khd_r <= signed'({1'b0, stiff_r}) * signed'(kdc_r[KD_W-1:LO_W]);
      kld_r <= stiff_r * kdc_r[LO_W-1:0];
      dhd_r <= signed'({1'b0, damp_r}) * signed'(wc_r[W_W-1:LO_W]);
      dld_r <= damp_r * wc_r[LO_W-1:0];
      ed_r  <= ec_r;
      zd_r  <= zc_r;
    end
  end

  // ---------------- stage E: recombine, floor scale ----------------
  logic signed [SC_W-1:0]   kse_r, dse_r;
  logic signed [UNIT_W-1:0] ee_r [3];
  logic                     ze_r, ve_r;

  always_ff @(posedge clk) begin
    if (en) begin
      kse_r <= (SC_W'(khd_r) <<< (LO_W - FRAC_W)) + signed'(SC_W'(kld_r >> FRAC_W));
      dse_r <= (SC_W'(dhd_r) <<< (LO_W - FRAC_W)) + signed'(SC_W'(dld_r >> FRAC_W));
      ee_r  <= ed_r;
      ze_r  <= zd_r;
    end
  end

  // ---------------- stage F: scalar force with clamp ----------------
  logic signed [SC_W:0]     fdiff;
  logic signed [F_W-1:0]    f_nxt, ff_r;
  logic signed [UNIT_W-1:0] ef_r [3];
  logic                     zf_r, vf_r;

  assign fdiff = (SC_W+1)'(kse_r) - (SC_W+1)'(dse_r);

  always_comb begin
    priority if (fdiff > (SC_W+1)'(F_LIM)) begin
      f_nxt = F_W'(F_LIM);
    end else if (fdiff < -(SC_W+1)'(F_LIM)) begin
      f_nxt = -F_W'(F_LIM);
    end else begin
      f_nxt = F_W'(fdiff);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ff_r <= f_nxt;
      ef_r <= ee_r;
      zf_r <= ze_r;
    end
  end

  // ---------------- stage G: force components ----------------
  logic signed [PF_W-1:0] pfg_r [3];
  logic                   zg_r, vg_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pfg_r[i] <= ff_r * ef_r[i];
      end
      zg_r <= zf_r;
    end
  end

  // ---------------- stage H: scale, saturate, output register ----------------
  logic signed [SH_W-1:0]    sh [3];
  logic signed [VALUE_W-1:0] fo [3];
  logic signed [VALUE_W-1:0] force_r [3];
  logic                      coin_r, vh_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sh[i] = SH_W'(pfg_r[i] >>> FRAC_W);
      priority if (zg_r) begin
        fo[i] = '0;
      end else if (sh[i] > SH_W'(OUT_MAX)) begin
        fo[i] = VALUE_W'(OUT_MAX);
      end else if (sh[i] < SH_W'(OUT_MIN)) begin
        fo[i] = VALUE_W'(OUT_MIN);
      end else begin
        fo[i] = VALUE_W'(sh[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      force_r <= fo;
      coin_r  <= zg_r;
    end
  end

  // Valid bits for the front and back stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
      vf_r <= 1'b0;
      vg_r <= 1'b0;
      vh_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      va_r <= v5;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
      ve_r <= vd_r;
      vf_r <= ve_r;
      vg_r <= vf_r;
      vh_r <= vg_r;
    end
  end

  assign out_valid      = vh_r;
  assign out_force_x    = force_r[0];
  assign out_force_y    = force_r[1];
  assign out_force_z    = force_r[2];
  assign out_coincident = coin_r;

  // Coincident bodies carry no force
  a_coin_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_coincident |->
      out_force_x == '0 && out_force_y == '0 && out_force_z == '0)
    else $error("coincident result with nonzero force");

  // Taking a result always frees the input side
  a_take_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |-> in_ready)
    else $error("input blocked while result transfers");

  // Nothing is presented right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

`default_nettype wire

>>> rtl/spr_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on spr_pkg.
`default_nettype none

module spr_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [spr_pkg::SQ_W-1:0]   in_rad,
  input  spr_pkg::spr_side_t         in_side,
  output logic                       out_valid,
  output logic [spr_pkg::ROOT_W-1:0] out_root,
  output spr_pkg::spr_side_t         out_side
);
  import spr_pkg::*;

  logic [ROOT_W-1:0] root_r [ROOT_W];
  logic [SQ_W-1:0]   rem_r  [ROOT_W];
  spr_side_t         side_r [ROOT_W];
  logic              vld_r  [ROOT_W];

  // Stage s decides root bit K; rem holds radicand minus root squared
  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    localparam int K = ROOT_W - 1 - s;
    logic [ROOT_W-1:0] root_in;
    logic [SQ_W-1:0]   rem_in;
    spr_side_t         side_in;
    logic              vld_in;
    logic [SQ_W:0]     step;
    logic              take;

    if (s == 0) begin : g_head
      assign root_in = '0;
      assign rem_in  = in_rad;
      assign side_in = in_side;
      assign vld_in  = in_valid;
    end else begin : g_body
      assign root_in = root_r[s-1];
      assign rem_in  = rem_r[s-1];
      assign side_in = side_r[s-1];
      assign vld_in  = vld_r[s-1];
    end

    // (r + 2^K)^2 - r^2 = r*2^(K+1) + 2^(2K)
    assign step = ((SQ_W+1)'(root_in) << (K + 1)) + ((SQ_W+1)'(1) << (2 * K));
    assign take = (SQ_W+1)'(rem_in) >= step;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[s] <= take ? (root_in | (ROOT_W'(1) << K)) : root_in;
        rem_r[s]  <= take ? SQ_W'((SQ_W+1)'(rem_in) - step) : rem_in;
        side_r[s] <= side_in;
      end
    end
  end

  assign out_valid = vld_r[ROOT_W-1];
  assign out_root  = root_r[ROOT_W-1];
  assign out_side  = side_r[ROOT_W-1];

endmodule

`default_nettype wire

>>> rtl/spr_div.sv
// Pipelined restoring divider, three lanes sharing one divisor (the length),
// one quotient bit per stage. Depends on spr_pkg.
`default_nettype none

module spr_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [spr_pkg::ROOT_W-1:0] in_root,
  input  spr_pkg::spr_side_t         in_side,
  output logic                       out_valid,
  output spr_pkg::spr_quot_t         out_quot
);
  import spr_pkg::*;

  spr_quot_t              qt_r  [QUO_W];
  logic [2:0][NUM_W-1:0]  rem_r [QUO_W];
  logic                   vld_r [QUO_W];

  // Numerators |d| * 2^FRAC_W and sign per axis
  logic [2:0][NUM_W-1:0] num;
  logic [2:0]            sgn;
  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic [DIFF_W-1:0] md;
    assign sgn[l] = in_side.d[l][DIFF_W-1];
    assign md     = sgn[l] ? (~in_side.d[l] + 1'b1) : in_side.d[l];
    assign num[l] = {md, FRAC_W'(0)};
  end

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    localparam int K = QUO_W - 1 - s;
    spr_quot_t             qt_in, qt_nxt;
    logic [2:0][NUM_W-1:0] rem_in, rem_nxt;
    logic                  vld_in;
    logic [NUM_W-1:0]      dvs;

    if (s == 0) begin : g_head
      always_comb begin
        qt_in      = '0;
        qt_in.neg  = sgn;
        qt_in.dv   = in_side.dv;
        qt_in.len  = in_root;
        qt_in.zero = in_side.zero;
      end
      assign rem_in = num;
      assign vld_in = in_valid;
    end else begin : g_body
      assign qt_in  = qt_r[s-1];
      assign rem_in = rem_r[s-1];
      assign vld_in = vld_r[s-1];
    end

    assign dvs = NUM_W'(qt_in.len) << K;

    // Trial subtract per lane
    always_comb begin
      qt_nxt  = qt_in;
      rem_nxt = rem_in;
      for (int l = 0; l < 3; l++) begin
        if (rem_in[l] >= dvs) begin
          rem_nxt[l]     = rem_in[l] - dvs;
          qt_nxt.q[l][K] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        qt_r[s]  <= qt_nxt;
        rem_r[s] <= rem_nxt;
      end
    end
  end

  assign out_valid = vld_r[QUO_W-1];
  assign out_quot  = qt_r[QUO_W-1];

  // Unit vector components never exceed 1.0 when the length is nonzero
  a_unit_x: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_quot.zero |-> out_quot.q[0] <= (QUO_W'(1) << FRAC_W))
    else $error("x unit component above one");
  a_unit_y: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_quot.zero |-> out_quot.q[1] <= (QUO_W'(1) << FRAC_W))
    else $error("y unit component above one");
  a_unit_z: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_quot.zero |-> out_quot.q[2] <= (QUO_W'(1) << FRAC_W))
    else $error("z unit component above one");

endmodule

`default_nettype wire

>>> bench/testbench.sv
// Self-checking bench for the damped_spring_force pipeline: directed table, then random
// spring pairs under several register settings and idle patterns. Depends on spr_pkg.
`default_nettype none

module testbench;
  import spr_pkg::*;

  localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;  // unmapped index, must be ignored
  localparam int PIPE_DRAIN = 80;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PER_PHASE = 258;
  localparam int PHASES = 6;

  typedef struct {
    logic signed [31:0] fx, fy, fz;
    logic               coin;
  } force_t;

  typedef struct {
    int     v[12];
    bit     typed;
    force_t want;
  } pair_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_first_x = 0, in_first_y = 0, in_first_z = 0;
  logic signed [31:0] in_second_x = 0, in_second_y = 0, in_second_z = 0;
  logic signed [31:0] in_first_vx = 0, in_first_vy = 0, in_first_vz = 0;
  logic signed [31:0] in_second_vx = 0, in_second_vy = 0, in_second_vz = 0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_force_x, out_force_y, out_force_z;
  logic out_coincident;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  // predictor's copy of the registers
  logic [CFG_W-1:0] k_spring, k_damp, rest_len;

  force_t pending_forces[$];
  pair_row_t pair_rows[$];
  int errors = 0;
  int stall_pct = 0;
  int cycles = 0;

  damped_spring_force dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // spring-damper force on the first body, bit exact
  function automatic force_t spring_force(input int v[12]);
    longint d[3], dv[3], e[3];
    longint unsigned mg, len, t, q;
    logic [127:0] sq;
    longint w;
    logic signed [127:0] a, b, f, p;
    force_t r;
    sq = '0;
    for (int i = 0; i < 3; i++) begin
      d[i] = longint'(v[3+i]) - longint'(v[i]);
      dv[i] = longint'(v[6+i]) - longint'(v[9+i]);
      mg = d[i] < 0 ? longint'(-d[i]) : longint'(d[i]);
      sq += 128'(mg) * 128'(mg);
    end
    if (sq == 0) begin
      r.fx = 0; r.fy = 0; r.fz = 0; r.coin = 1'b1;
      return r;
    end
    // integer square root
    len = 0;
    for (int bt = 39; bt >= 0; bt--) begin
      t = len | (64'd1 << bt);
      if (128'(t) * 128'(t) <= sq) len = t;
    end
    w = 0;
    for (int i = 0; i < 3; i++) begin
      mg = d[i] < 0 ? longint'(-d[i]) : longint'(d[i]);
      q = (mg << FRAC_W) / len;
      e[i] = d[i] < 0 ? -longint'(q) : longint'(q);
      w += e[i] * dv[i];
    end
    w = w >>> FRAC_W;
    a = $signed({97'd0, k_spring});
    b = longint'(len) - longint'({33'd0, rest_len});
    f = (a * b) >>> FRAC_W;
    a = $signed({97'd0, k_damp});
    b = w;
    f = f - ((a * b) >>> FRAC_W);
    if (f > (128'sd1 <<< 47) - 1) f = (128'sd1 <<< 47) - 1;
    if (f < -((128'sd1 <<< 47) - 1)) f = -((128'sd1 <<< 47) - 1);
    for (int i = 0; i < 3; i++) begin
      b = e[i];
      p = (f * b) >>> FRAC_W;
      if (p > 128'sd2147483647) p = 128'sd2147483647;
      if (p < -128'sd2147483648) p = -128'sd2147483648;
      if (i == 0) r.fx = p[31:0];
      else if (i == 1) r.fy = p[31:0];
      else r.fz = p[31:0];
    end
    r.coin = 1'b0;
    return r;
  endfunction

  // result side: random stall and compare against the oldest expectation
  always @(posedge clk) begin
    force_t x;
    if (rst_n && out_valid && out_ready) begin
      if (pending_forces.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
      end else begin
        x = pending_forces.pop_front();
        if (out_force_x !== x.fx) begin
          $error("force_x expected %0d got %0d", x.fx, out_force_x); errors++;
        end
        if (out_force_y !== x.fy) begin
          $error("force_y expected %0d got %0d", x.fy, out_force_y); errors++;
        end
        if (out_force_z !== x.fz) begin
          $error("force_z expected %0d got %0d", x.fz, out_force_z); errors++;
        end
        if (out_coincident !== x.coin) begin
          $error("coincident expected %0d got %0d", x.coin, out_coincident); errors++;
        end
      end
    end
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_STIFFNESS) k_spring = val;
    else if (idx == REG_DAMPING) k_damp = val;
    else if (idx == REG_REST_LENGTH) rest_len = val;
    @(posedge clk);
  endtask

  // one pair transfer; idles first with the given percentage
  task automatic send_pair(input pair_row_t row, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_first_x <= row.v[0];  in_first_y <= row.v[1];  in_first_z <= row.v[2];
    in_second_x <= row.v[3]; in_second_y <= row.v[4]; in_second_z <= row.v[5];
    in_first_vx <= row.v[6]; in_first_vy <= row.v[7]; in_first_vz <= row.v[8];
    in_second_vx <= row.v[9]; in_second_vy <= row.v[10]; in_second_vz <= row.v[11];
    do @(posedge clk); while (!in_ready);
    pending_forces.push_back(row.typed ? row.want : spring_force(row.v));
  endtask

  function automatic int pick_extreme();
    case ($urandom_range(3))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 0;
      default: return int'($urandom);
    endcase
  endfunction

  function automatic int signed_bits(input int w);
    return int'($urandom) >>> (32 - w);
  endfunction

  // random pair: mostly springs of sane size, some coincident, some wild
  function automatic pair_row_t random_pair();
    pair_row_t r;
    int kind;
    kind = $urandom_range(9);
    r.typed = 1'b0;
    for (int i = 0; i < 12; i++) r.v[i] = int'($urandom);
    if (kind == 0) begin
      for (int i = 0; i < 12; i++) r.v[i] = pick_extreme();
    end else if (kind == 1) begin
      for (int i = 0; i < 3; i++) r.v[3+i] = r.v[i];
    end else if (kind > 2) begin
      for (int i = 0; i < 3; i++) begin
        r.v[i] = signed_bits($urandom_range(1, 28));
        r.v[3+i] = r.v[i] + signed_bits($urandom_range(1, 20));
      end
      for (int i = 6; i < 12; i++) r.v[i] = signed_bits($urandom_range(1, 24));
    end
    return r;
  endfunction

  function automatic void add_row(input int p[6], input bit typed,
                                  input int fx, input int fy, input int fz, input bit c);
    pair_row_t r;
    for (int i = 0; i < 6; i++) r.v[i] = p[i];
    for (int i = 6; i < 12; i++) r.v[i] = 0;
    r.typed = typed;
    r.want.fx = fx; r.want.fy = fy; r.want.fz = fz; r.want.coin = c;
    pair_rows.push_back(r);
  endfunction

  initial begin
    pair_row_t r;
    int idle_pct;
    k_spring = 31'd65536; k_damp = '0; rest_len = 31'd65536;

    // directed table, checked under reset register values
    add_row('{0, 0, 0, 0, 0, 0}, 1, 0, 0, 0, 1);
    add_row('{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
              32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000}, 1, 0, 0, 0, 1);
    add_row('{0, 0, 0, 65536, 0, 0}, 1, 0, 0, 0, 0);        // at rest length
    add_row('{0, 0, 0, 131072, 0, 0}, 1, 65536, 0, 0, 0);   // stretched by 1.0
    add_row('{0, 0, 0, 0, -131072, 0}, 1, 0, -65536, 0, 0);
    add_row('{0, 0, 0, 0, 0, 32768}, 1, 0, 0, -32768, 0);    // compressed by 0.5
    add_row('{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
              32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff}, 0, 0, 0, 0, 0);
    add_row('{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
              32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000}, 0, 0, 0, 0, 0);
    add_row('{32'sh5555_5555, 32'shaaaa_aaaa, 32'sh5555_5555,
              32'shaaaa_aaaa, 32'sh5555_5555, 32'shaaaa_aaaa}, 0, 0, 0, 0, 0);
    add_row('{0, 0, 0, 1, 0, 0}, 0, 0, 0, 0, 0);              // shortest spring
    add_row('{0, 0, 0, 0, 1, 1}, 0, 0, 0, 0, 0);
    // velocity extremes along the axis
    r = pair_rows[3]; r.typed = 0;
    for (int i = 6; i < 12; i++) r.v[i] = i[0] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    pair_rows.push_back(r);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int ph = 0; ph < PHASES; ph++) begin
      // registers change only with the pipeline empty
      while (pending_forces.size() != 0) @(posedge clk);
      repeat (PIPE_DRAIN) @(posedge clk);
      case (ph)
        1: begin
          write_reg(REG_STIFFNESS, '1);
          write_reg(REG_DAMPING, '1);
          write_reg(REG_REST_LENGTH, '1);
        end
        2: begin
          write_reg(REG_STIFFNESS, '0);
          write_reg(REG_DAMPING, '0);
          write_reg(REG_REST_LENGTH, '0);
          write_reg(REG_SPARE, '1);
        end
        3: begin
          write_reg(REG_STIFFNESS, 31'd655360);  // 10.0
          write_reg(REG_DAMPING, 31'd32768);     // 0.5
          write_reg(REG_REST_LENGTH, 31'd131072);
        end
        4, 5: begin
          write_reg(REG_STIFFNESS, CFG_W'($urandom_range(0, 32'h7fff_ffff)));
          write_reg(REG_DAMPING, CFG_W'($urandom) >> $urandom_range(0, 30));
          write_reg(REG_REST_LENGTH, CFG_W'($urandom) >> $urandom_range(0, 30));
        end
        default: ;
      endcase
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 76; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 76; end
        default: begin idle_pct = 12; stall_pct = 12; end
      endcase
      if (ph == 0)
        foreach (pair_rows[i]) send_pair(pair_rows[i], idle_pct);
      for (int n = 0; n < RANDOM_PER_PHASE; n++) send_pair(random_pair(), idle_pct);
      in_valid <= 1'b0;
    end

    while (pending_forces.size() != 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
    if (errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire
